// File: hdl/bcm_pkg.sv
// bcm_pkg: shared types, sizes and codes of the body collision merge block
// used by bcm_ctrl, bcm_dp, bcm_checker and the top level body_collision_merge
package bcm_pkg;

  localparam int MAX_BODIES = 64;
  localparam int DIMS       = 3;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int AXIS_W     = 2;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int GROWTH_W   = 17;
  localparam logic [GROWTH_W-1:0] GROWTH_RESET = GROWTH_W'(65536);

  // one stored body, all axes kept; axes beyond DIMS hold zero
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      mass;
    logic [31:0]      radius;
    logic             active;
  } body_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_I_RD,
    S_I_CAP,
    S_J_RD,
    S_J_CAP,
    S_DIST_MUL,
    S_DIST_ACC,
    S_RAD_MUL,
    S_RAD_CMP,
    S_VEL_MUL,
    S_DIV_LD,
    S_DIV,
    S_VEL_UPD,
    S_GROW_MUL,
    S_MERGE_UPD,
    S_WR_J,
    S_WR_I,
    S_E_RD,
    S_E_CAP,
    S_E_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_DIST,
    MUL_RSUM,
    MUL_VEL,
    MUL_GROW
  } mul_sel_e;

  typedef enum logic [1:0] {
    WR_LOAD,
    WR_J,
    WR_I
  } wr_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    wr_sel_e           wr_sel;
    logic [IDX_W-1:0]  wr_addr;
    logic              cap_i;
    logic              cap_j;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic [AXIS_W-1:0] axis;
    logic              acc_clr;
    logic              acc_en;
    logic              cmp_en;
    logic              div_load;
    logic              div_step;
    logic              vel_upd;
    logic              merge_upd;
    logic              out_cap;
    logic              out_last;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic rd_active;
    logic overlap;
    logic heavy_j;
    logic div_last;
  } status_t;

endpackage

// File: hdl/bcm_ctrl.sv
// bcm_ctrl: sequencer of the body collision merge block
// walks loads, the pair loop, the merge steps and the emission; uses bcm_pkg
module bcm_ctrl import bcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    operation_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  bi_q, bi_d;
  logic [IDX_W-1:0]  bj_q, bj_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              last_i, last_j, last_k, last_axis, store_full;

  assign last_i     = (CNT_W'(bi_q) + CNT_W'(1)) == count_q;
  assign last_j     = (CNT_W'(bj_q) + CNT_W'(1)) == count_q;
  assign last_k     = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
  assign last_axis  = axis_q == AXIS_W'(DIMS - 1);
  assign store_full = count_q == CNT_W'(MAX_BODIES);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      bi_q    <= '0;
      bj_q    <= '0;
      k_q     <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bi_q    <= bi_d;
      bj_q    <= bj_d;
      k_q     <= k_d;
      axis_q  <= axis_d;
    end
  end

  // next state and loop indexes
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    bi_d    = bi_q;
    bj_d    = bj_q;
    k_d     = k_q;
    axis_d  = axis_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!operation_i) begin
            if (!store_full) count_d = count_q + CNT_W'(1);
          end else if (count_q != '0) begin
            bi_d    = '0;
            state_d = S_I_RD;
          end
        end
      end
      S_I_RD: state_d = S_I_CAP;
      S_I_CAP: begin
        if (!status_i.rd_active || last_i) begin
          if (last_i) begin
            k_d     = '0;
            state_d = S_E_RD;
          end else begin
            bi_d    = bi_q + IDX_W'(1);
            state_d = S_I_RD;
          end
        end else begin
          bj_d    = bi_q + IDX_W'(1);
          state_d = S_J_RD;
        end
      end
      S_J_RD: state_d = S_J_CAP;
      S_J_CAP: begin
        if (!status_i.rd_active) begin
          if (last_j) state_d = S_WR_I;
          else begin
            bj_d    = bj_q + IDX_W'(1);
            state_d = S_J_RD;
          end
        end else begin
          axis_d  = '0;
          state_d = S_DIST_MUL;
        end
      end
      S_DIST_MUL: state_d = S_DIST_ACC;
      S_DIST_ACC: begin
        if (last_axis) state_d = S_RAD_MUL;
        else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = S_DIST_MUL;
        end
      end
      S_RAD_MUL: state_d = S_RAD_CMP;
      S_RAD_CMP: begin
        if (!status_i.overlap) begin
          if (last_j) state_d = S_WR_I;
          else begin
            bj_d    = bj_q + IDX_W'(1);
            state_d = S_J_RD;
          end
        end else begin
          axis_d  = '0;
          state_d = S_VEL_MUL;
        end
      end
      S_VEL_MUL: state_d = S_DIV_LD;
      S_DIV_LD:  state_d = S_DIV;
      S_DIV: begin
        if (status_i.div_last) state_d = S_VEL_UPD;
      end
      S_VEL_UPD: begin
        if (last_axis) state_d = S_GROW_MUL;
        else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = S_VEL_MUL;
        end
      end
      S_GROW_MUL:  state_d = S_MERGE_UPD;
      S_MERGE_UPD: state_d = S_WR_J;
      S_WR_J: begin
        // body i absorbed: its inner loop stops
        if (status_i.heavy_j || last_j) state_d = S_WR_I;
        else begin
          bj_d    = bj_q + IDX_W'(1);
          state_d = S_J_RD;
        end
      end
      S_WR_I: begin
        if (last_i) begin
          k_d     = '0;
          state_d = S_E_RD;
        end else begin
          bi_d    = bi_q + IDX_W'(1);
          state_d = S_I_RD;
        end
      end
      S_E_RD:  state_d = S_E_CAP;
      S_E_CAP: state_d = S_E_OUT;
      S_E_OUT: begin
        if (!out_stall_i) begin
          if (last_k) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = S_E_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands and handshake outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_sel  = WR_LOAD;
    cmd_o.mul_sel = MUL_DIST;
    cmd_o.axis    = axis_q;
    cmd_o.wr_addr = count_q[IDX_W-1:0];
    cmd_o.rd_addr = bi_q;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.wr_en = in_valid_i && !operation_i && !store_full;
      end
      S_I_RD:     cmd_o.rd_addr = bi_q;
      S_I_CAP:    cmd_o.cap_i = 1'b1;
      S_J_RD:     cmd_o.rd_addr = bj_q;
      S_J_CAP: begin
        cmd_o.cap_j   = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      S_DIST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DIST;
      end
      S_DIST_ACC: cmd_o.acc_en = 1'b1;
      S_RAD_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RSUM;
      end
      S_RAD_CMP:  cmd_o.cmp_en = 1'b1;
      S_VEL_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VEL;
      end
      S_DIV_LD:   cmd_o.div_load = 1'b1;
      S_DIV:      cmd_o.div_step = 1'b1;
      S_VEL_UPD:  cmd_o.vel_upd = 1'b1;
      S_GROW_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GROW;
      end
      S_MERGE_UPD: cmd_o.merge_upd = 1'b1;
      S_WR_J: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_J;
        cmd_o.wr_addr = bj_q;
      end
      S_WR_I: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_I;
        cmd_o.wr_addr = bi_q;
      end
      S_E_RD:     cmd_o.rd_addr = k_q;
      S_E_CAP: begin
        cmd_o.out_cap  = 1'b1;
        cmd_o.out_last = last_k;
      end
      S_E_OUT:    out_valid_o = 1'b1;
      default:    cmd_o.rd_addr = bi_q;
    endcase
  end

endmodule

// File: hdl/bcm_dp.sv
// bcm_dp: datapath of the body collision merge block
// body memory, pair registers, shared multiplier, serial divider; uses bcm_pkg
module bcm_dp import bcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [GROWTH_W-1:0] cfg_wdata_i,
  input  body_t               ld_body_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output body_t               out_body_o,
  output logic                out_last_o
);

  body_t                mem_q [MAX_BODIES];
  body_t                rdata_q;
  body_t                wr_data, ld_clean;
  body_t                i_q, j_q, h_b, l_b;
  body_t                out_q;
  logic                 out_last_q;
  logic [GROWTH_W-1:0]  gf_q;
  logic                 heavy_j_q;
  logic [32:0]          mul_a, mul_b;
  logic [65:0]          prod_q, acc_q;
  logic [63:0]          quo_q;
  logic [32:0]          rem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic signed [32:0]   dpos, dvel;
  logic [32:0]          dpos_mag, dvel_mag, rsum, mass_sum;
  logic [33:0]          rem_sh, rem_sub;
  logic                 rem_ge;
  logic [33:0]          qq, vl_ext, vel_res;
  logic [31:0]          vel_new, mass_new, rad_new;
  logic [33:0]          rad_sum;

  // growth factor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gf_q <= GROWTH_RESET;
    else if (cfg_we_i) gf_q <= cfg_wdata_i;
  end

  // loaded body with unused axes cleared
  always_comb begin
    ld_clean = ld_body_i;
    for (int c = 0; c < 3; c++) begin
      if (c >= DIMS) begin
        ld_clean.pos[c] = '0;
        ld_clean.vel[c] = '0;
      end
    end
  end

  // write data select
  always_comb begin
    case (cmd_i.wr_sel)
      WR_LOAD: wr_data = ld_clean;
      WR_J:    wr_data = j_q;
      WR_I:    wr_data = i_q;
      default: wr_data = ld_clean;
    endcase
  end

  // body memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.wr_addr] <= wr_data;
    rdata_q <= mem_q[cmd_i.rd_addr];
  end

  // heavier and lighter body of the current pair
  assign h_b = heavy_j_q ? j_q : i_q;
  assign l_b = heavy_j_q ? i_q : j_q;

  // axis differences and magnitudes
  assign dpos     = {j_q.pos[cmd_i.axis][31], j_q.pos[cmd_i.axis]}
                  - {i_q.pos[cmd_i.axis][31], i_q.pos[cmd_i.axis]};
  assign dpos_mag = dpos[32] ? 33'(-dpos) : 33'(dpos);
  assign dvel     = {h_b.vel[cmd_i.axis][31], h_b.vel[cmd_i.axis]}
                  - {l_b.vel[cmd_i.axis][31], l_b.vel[cmd_i.axis]};
  assign dvel_mag = dvel[32] ? 33'(-dvel) : 33'(dvel);
  assign rsum     = {1'b0, i_q.radius} + {1'b0, j_q.radius};
  assign mass_sum = {1'b0, h_b.mass} + {1'b0, l_b.mass};

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DIST: begin
        mul_a = dpos_mag;
        mul_b = dpos_mag;
      end
      MUL_RSUM: begin
        mul_a = rsum;
        mul_b = rsum;
      end
      MUL_VEL: begin
        mul_a = dvel_mag;
        mul_b = {1'b0, h_b.mass};
      end
      MUL_GROW: begin
        mul_a = {1'b0, l_b.radius};
        mul_b = {16'b0, gf_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register and distance accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_en) acc_q <= acc_q + prod_q;
  end

  // pair decision, equal mass makes body j the heavier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) heavy_j_q <= 1'b0;
    else if (cmd_i.cmp_en) heavy_j_q <= !(i_q.mass > j_q.mass);
  end

  // restoring divider step, one quotient bit a cycle
  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_ge  = rem_sh >= {1'b0, mass_sum};
  assign rem_sub = rem_sh - {1'b0, mass_sum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else if (cmd_i.div_load) dcnt_q <= '0;
    else if (cmd_i.div_step) dcnt_q <= dcnt_q + DIV_CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q <= prod_q[63:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[62:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[32:0] : rem_sh[32:0];
    end
  end

  // merged velocity, rounded toward minus infinity
  assign qq      = {1'b0, quo_q[32:0]} + 34'(dvel[32] && (rem_q != '0));
  assign vl_ext  = {{2{l_b.vel[cmd_i.axis][31]}}, l_b.vel[cmd_i.axis]};
  assign vel_res = dvel[32] ? vl_ext - qq : vl_ext + qq;
  assign vel_new = (mass_sum == '0) ? h_b.vel[cmd_i.axis] : vel_res[31:0];

  // saturated mass and grown radius
  assign mass_new = mass_sum[32] ? '1 : mass_sum[31:0];
  assign rad_sum  = {2'b0, h_b.radius} + {1'b0, prod_q[48:16]};
  assign rad_new  = (rad_sum[33:32] != 2'b0) ? '1 : rad_sum[31:0];

  // pair registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_i) i_q <= rdata_q;
    if (cmd_i.cap_j) j_q <= rdata_q;
    if (cmd_i.vel_upd) begin
      if (heavy_j_q) j_q.vel[cmd_i.axis] <= vel_new;
      else i_q.vel[cmd_i.axis] <= vel_new;
    end
    if (cmd_i.merge_upd) begin
      if (heavy_j_q) begin
        j_q.mass   <= mass_new;
        j_q.radius <= rad_new;
        i_q.active <= 1'b0;
      end else begin
        i_q.mass   <= mass_new;
        i_q.radius <= rad_new;
        j_q.active <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_cap) begin
      out_q      <= rdata_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_body_o         = out_q;
  assign out_last_o         = out_last_q;
  assign status_o.rd_active = rdata_q.active;
  assign status_o.overlap   = acc_q < prod_q;
  assign status_o.heavy_j   = heavy_j_q;
  assign status_o.div_last  = dcnt_q == DIV_CNT_W'(DIV_STEPS - 1);

endmodule

// File: hdl/body_collision_merge.sv
// body_collision_merge: top level of the body store with a merge pass
// joins bcm_ctrl and bcm_dp; uses bcm_pkg
//
// Usage: an input item with operation 0 loads one body into the next free
// slot (up to MAX_BODIES; further loads are dropped) and returns nothing.
// An item with operation 1 runs the merge pass over all loaded pairs and
// then emits every loaded body in slot order, last_body_o marking the
// final one; the store then starts a new set. A run with no bodies emits
// nothing. growth_factor is written through cfg_we_i / cfg_wdata_i.
// Timing: loads are taken back to back. A run holds
// in_stall_o high until the last body is taken. Pair checks and
// merges share the single multiplier and the one bit a cycle divider.
// Emission steps through a read, a capture and an output state for
// each body, plus any receiver stall; while out_stall_i is high the
// output register holds its item.
// Reset: loaded count cleared, growth_factor back to 1.0, block idle.
module body_collision_merge import bcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [GROWTH_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  vel_z_i,
  input  logic [31:0]         body_mass_i,
  input  logic [31:0]         body_radius_i,
  input  logic                is_active_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  out_pos_x_o,
  output logic signed [31:0]  out_pos_y_o,
  output logic signed [31:0]  out_pos_z_o,
  output logic signed [31:0]  out_vel_x_o,
  output logic signed [31:0]  out_vel_y_o,
  output logic signed [31:0]  out_vel_z_o,
  output logic [31:0]         out_mass_o,
  output logic [31:0]         out_radius_o,
  output logic                out_active_o,
  output logic                last_body_o
);

  cmd_t    cmd;
  status_t status;
  body_t   ld_body, out_body;

  // incoming body
  assign ld_body.pos    = {pos_z_i, pos_y_i, pos_x_i};
  assign ld_body.vel    = {vel_z_i, vel_y_i, vel_x_i};
  assign ld_body.mass   = body_mass_i;
  assign ld_body.radius = body_radius_i;
  assign ld_body.active = is_active_i;

  bcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ld_body_i   (ld_body),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_body_o  (out_body),
    .out_last_o  (last_body_o)
  );

  // outgoing body
  assign out_pos_x_o  = out_body.pos[0];
  assign out_pos_y_o  = out_body.pos[1];
  assign out_pos_z_o  = out_body.pos[2];
  assign out_vel_x_o  = out_body.vel[0];
  assign out_vel_y_o  = out_body.vel[1];
  assign out_vel_z_o  = out_body.vel[2];
  assign out_mass_o   = out_body.mass;
  assign out_radius_o = out_body.radius;
  assign out_active_o = out_body.active;

endmodule

// File: hdl/bcm_checker.sv
// bcm_checker: port level checks of body_collision_merge and its bind
// sees only top level ports; uses bcm_pkg for the register width
module bcm_checker import bcm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [GROWTH_W-1:0] cfg_wdata_i,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                operation_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [31:0]         out_mass_o,
  input logic                last_body_o
);

  // no new item is taken while a body is being emitted
  a_no_accept_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during emission");

  // a load item produces no output
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !operation_i) |=> !out_valid_o)
    else $error("output after a load");

  // emission ends after the last body is taken
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_body_o) |=> !out_valid_o)
    else $error("output continues after last body");

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_mass_o) && $stable(last_body_o)))
    else $error("stalled output changed");

endmodule

bind body_collision_merge bcm_checker u_bcm_checker (.*);
